FILE: rtl/crr_pkg.sv
// ----------------------------------------------------------------------------
// crr_pkg
// Shared widths, types, register codes and helpers for the centred range
// rescale block.
// ----------------------------------------------------------------------------
package crr_pkg;

	// width of every axis value and register
	localparam int VALUE_BITS = 16;
	localparam int PROD_BITS  = 2 * VALUE_BITS;

	// configuration port
	localparam int DATA_BITS = 32;
	localparam int ADDR_BITS = 5;
	localparam int REG_COUNT = 6;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [VALUE_BITS:0]   wide_t;
	typedef logic        [VALUE_BITS-1:0] mag_t;
	typedef logic        [PROD_BITS-1:0]  prod_t;

	// register map, word index
	typedef enum logic [2:0] {
		REG_SRC_MIN    = 3'd0,
		REG_SRC_CENTER = 3'd1,
		REG_SRC_MAX    = 3'd2,
		REG_DST_MIN    = 3'd3,
		REG_DST_CENTER = 3'd4,
		REG_DST_MAX    = 3'd5
	} reg_idx_t;

	// reset values, truncated to the value width
	localparam value_t SRC_MIN_RST    = value_t'(-32768);
	localparam value_t SRC_CENTER_RST = value_t'(0);
	localparam value_t SRC_MAX_RST    = value_t'(32767);
	localparam value_t DST_MIN_RST    = value_t'(0);
	localparam value_t DST_CENTER_RST = value_t'(128);
	localparam value_t DST_MAX_RST    = value_t'(255);

	// calibration registers as seen by the datapath
	typedef struct packed {
		value_t src_min;
		value_t src_center;
		value_t src_max;
		value_t dst_min;
		value_t dst_center;
		value_t dst_max;
	} cfg_t;

	// per-request control that travels alongside the datapath
	typedef struct packed {
		logic bypass;   // result is the target centre
		logic neg;      // subtract the quotient from the target centre
	} side_t;

	// sign extension by one bit
	function automatic wide_t widen(value_t x);
		return wide_t'(x);
	endfunction

	// magnitude of a one-bit-wider difference
	function automatic mag_t mag_of(wide_t x);
		wide_t n;
		n = -x;
		return x[VALUE_BITS] ? n[VALUE_BITS-1:0] : x[VALUE_BITS-1:0];
	endfunction

endpackage

FILE: rtl/crr_regs.sv
// ----------------------------------------------------------------------------
// crr_regs
// Calibration register bank behind a simple APB-style port.
// ----------------------------------------------------------------------------
module crr_regs import crr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	output cfg_t                 cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;
	value_t   wdata;

	function automatic logic [DATA_BITS-1:0] sext_word(value_t v);
		return DATA_BITS'(v);
	endfunction

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_BITS-1:2]);
	assign wdata  = pwdata[VALUE_BITS-1:0];
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.src_min    <= SRC_MIN_RST;
			cfg_q.src_center <= SRC_CENTER_RST;
			cfg_q.src_max    <= SRC_MAX_RST;
			cfg_q.dst_min    <= DST_MIN_RST;
			cfg_q.dst_center <= DST_CENTER_RST;
			cfg_q.dst_max    <= DST_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_SRC_MIN:    cfg_q.src_min    <= wdata;
				REG_SRC_CENTER: cfg_q.src_center <= wdata;
				REG_SRC_MAX:    cfg_q.src_max    <= wdata;
				REG_DST_MIN:    cfg_q.dst_min    <= wdata;
				REG_DST_CENTER: cfg_q.dst_center <= wdata;
				REG_DST_MAX:    cfg_q.dst_max    <= wdata;
				default:        ;
			endcase
		end
	end

	// read mux, sign extended
	always_comb begin
		unique case (idx)
			REG_SRC_MIN:    prdata = sext_word(cfg_q.src_min);
			REG_SRC_CENTER: prdata = sext_word(cfg_q.src_center);
			REG_SRC_MAX:    prdata = sext_word(cfg_q.src_max);
			REG_DST_MIN:    prdata = sext_word(cfg_q.dst_min);
			REG_DST_CENTER: prdata = sext_word(cfg_q.dst_center);
			REG_DST_MAX:    prdata = sext_word(cfg_q.dst_max);
			default:        prdata = '0;
		endcase
	end

endmodule

FILE: rtl/crr_prep.sv
// ----------------------------------------------------------------------------
// crr_prep
// Front of the pipeline: clamp, centre distance and source half-range in
// stage 1, target half-range and result sign in stage 2.
// ----------------------------------------------------------------------------
module crr_prep import crr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   raw_valid,
	input  value_t raw_value,
	input  cfg_t   cfg,
	output logic   vld,
	output side_t  side,
	output mag_t   span,
	output mag_t   delta,
	output mag_t   half
);

	logic   src_up, src_flat, dist_pos, pos;
	value_t lo, hi, v;
	wide_t  dist_w, half_w;

	logic   vld_s1, bypass_s1, pos_s1;
	mag_t   dist_s1, half_s1;

	logic   dst_up, neg;
	wide_t  span_w;

	logic   vld_s2;
	side_t  side_s2;
	mag_t   span_s2, dist_s2, half_s2;

	// clamp into the source range and pick the source segment
	always_comb begin
		src_up   = cfg.src_max > cfg.src_min;
		src_flat = cfg.src_max == cfg.src_min;
		lo       = src_up ? cfg.src_min : cfg.src_max;
		hi       = src_up ? cfg.src_max : cfg.src_min;
		v        = raw_value;
		if (raw_value > hi) begin
			v = hi;
		end else if (raw_value < lo) begin
			v = lo;
		end
		dist_w   = widen(v) - widen(cfg.src_center);
		dist_pos = !dist_w[VALUE_BITS] && (dist_w != '0);
		if (src_up) begin
			half_w = dist_pos ? widen(cfg.src_max) - widen(cfg.src_center)
			                  : widen(cfg.src_center) - widen(cfg.src_min);
			pos    = dist_pos;
		end else begin
			half_w = dist_pos ? widen(cfg.src_min) - widen(cfg.src_center)
			                  : widen(cfg.src_center) - widen(cfg.src_max);
			pos    = !dist_pos;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= raw_valid;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (en) begin
			bypass_s1 <= src_flat || (v == cfg.src_center);
			pos_s1    <= pos;
			dist_s1   <= mag_of(dist_w);
			half_s1   <= mag_of(half_w);
		end
	end

	// target segment and sign of the correction
	always_comb begin
		dst_up = cfg.dst_max > cfg.dst_min;
		if (dst_up) begin
			span_w = pos_s1 ? widen(cfg.dst_max) - widen(cfg.dst_center)
			                : widen(cfg.dst_center) - widen(cfg.dst_min);
		end else begin
			span_w = pos_s1 ? widen(cfg.dst_center) - widen(cfg.dst_max)
			                : widen(cfg.dst_min) - widen(cfg.dst_center);
		end
		neg = (span_w[VALUE_BITS] ^ !pos_s1) ^ !dst_up;
	end

	// stage 2 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	// stage 2 payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.bypass <= bypass_s1;
			side_s2.neg    <= neg;
			span_s2        <= mag_of(span_w);
			dist_s2        <= dist_s1;
			half_s2        <= half_s1;
		end
	end

	assign vld   = vld_s2;
	assign side  = side_s2;
	assign span  = span_s2;
	assign delta = dist_s2;
	assign half  = half_s2;

endmodule

FILE: rtl/crr_divider.sv
// ----------------------------------------------------------------------------
// crr_divider
// Product of target half-range and distance in stage 3, then a restoring
// divide by the source half-range, one quotient bit per stage.
// ----------------------------------------------------------------------------
module crr_divider import crr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  vld_in,
	input  side_t side_in,
	input  mag_t  span,
	input  mag_t  delta,
	input  mag_t  half,
	output logic  vld,
	output side_t side,
	output mag_t  quo
);

	localparam int MUL_STG  = 3;
	localparam int LAST_STG = MUL_STG + VALUE_BITS;

	prod_t prod;

	logic  vld_s  [MUL_STG:LAST_STG];
	side_t side_s [MUL_STG:LAST_STG];
	prod_t rem_s  [MUL_STG:LAST_STG-1];
	mag_t  half_s [MUL_STG:LAST_STG-1];
	mag_t  quo_s  [MUL_STG+1:LAST_STG];

	assign prod = {{VALUE_BITS{1'b0}}, span} * {{VALUE_BITS{1'b0}}, delta};

	// stage 3 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[MUL_STG] <= 1'b0;
		end else if (en) begin
			vld_s[MUL_STG] <= vld_in;
		end
	end

	// stage 3 payload
	always_ff @(posedge clk) begin
		if (en) begin
			side_s[MUL_STG] <= side_in;
			rem_s[MUL_STG]  <= prod;
			half_s[MUL_STG] <= half;
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar k = 0; k < VALUE_BITS; k++) begin : g_div
		localparam int STG  = MUL_STG + k;
		localparam int QBIT = VALUE_BITS - 1 - k;

		prod_t trial;
		logic  ge;
		mag_t  quo_prev;
		mag_t  quo_nxt;

		if (k == 0) begin : g_first
			assign quo_prev = '0;
		end else begin : g_rest
			assign quo_prev = quo_s[STG];
		end

		assign trial   = prod_t'(half_s[STG]) << QBIT;
		assign ge      = rem_s[STG] >= trial;
		assign quo_nxt = quo_prev | (mag_t'(ge) << QBIT);

		// valid follows the data
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[STG+1] <= 1'b0;
			end else if (en) begin
				vld_s[STG+1] <= vld_s[STG];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				side_s[STG+1] <= side_s[STG];
				quo_s[STG+1]  <= quo_nxt;
			end
		end

		// remainder and divisor are not needed after the last bit
		if (k < VALUE_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[STG+1]  <= ge ? rem_s[STG] - trial : rem_s[STG];
					half_s[STG+1] <= half_s[STG];
				end
			end
		end
	end

	assign vld  = vld_s[LAST_STG];
	assign side = side_s[LAST_STG];
	assign quo  = quo_s[LAST_STG];

endmodule

FILE: rtl/crr_outbuf.sv
// ----------------------------------------------------------------------------
// crr_outbuf
// Final add around the target centre, output register and skid register.
// Drives the pipeline enable.
// ----------------------------------------------------------------------------
module crr_outbuf import crr_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   vld_in,
	input  side_t  side_in,
	input  mag_t   quo,
	input  value_t dst_center,
	input  logic   scaled_ready,
	output logic   en,
	output logic   scaled_valid,
	output value_t scaled_value
);

	value_t res;
	logic   take;
	logic   out_vld_q, skid_vld_q;
	value_t out_data_q, skid_data_q;

	// result wraps to the value width
	always_comb begin
		if (side_in.bypass) begin
			res = dst_center;
		end else if (side_in.neg) begin
			res = dst_center - value_t'(quo);
		end else begin
			res = dst_center + value_t'(quo);
		end
	end

	// pipeline moves while the skid register is empty
	assign en   = !skid_vld_q;
	assign take = out_vld_q && scaled_ready;

	// output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (take) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!out_vld_q || take) begin
			out_vld_q <= vld_in;
		end else if (vld_in) begin
			skid_vld_q <= 1'b1;
		end
	end

	// output and skid data
	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (take) begin
				out_data_q <= skid_data_q;
			end
		end else if (!out_vld_q || take) begin
			out_data_q <= res;
		end else begin
			skid_data_q <= res;
		end
	end

	assign scaled_valid = out_vld_q;
	assign scaled_value = out_data_q;

endmodule

FILE: rtl/centered_range_rescale.sv
// ----------------------------------------------------------------------------
// centered_range_rescale
// Piecewise-linear axis calibration around a centre point, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one request per clock when the output is not held off. The
// restoring divider resolves one quotient bit per pipeline stage;
// clamp with source half-range, target half-range and multiply take one
// stage each, and the final add feeds the output register.
// A skid register behind the output
// lets one further request in while a result waits; raw_ready drops only
// once both are full. Calibration registers sit at byte addresses 0, 4, ...,
// 20 (src_min, src_center, src_max, dst_min, dst_center, dst_max) and are
// to be written only while no request is in flight.
// ----------------------------------------------------------------------------
module centered_range_rescale import crr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [DATA_BITS-1:0] pwdata,
	output logic [DATA_BITS-1:0] prdata,
	output logic                 pready,
	input  logic                 raw_valid,
	output logic                 raw_ready,
	input  value_t               raw_value,
	output logic                 scaled_valid,
	input  logic                 scaled_ready,
	output value_t               scaled_value
);

	cfg_t  cfg;
	logic  en;
	logic  prep_vld, div_vld;
	side_t prep_side, div_side;
	mag_t  prep_span, prep_dist, prep_half, div_quo;

	assign raw_ready = en;

	// calibration registers
	crr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// clamp and segment selection
	crr_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.raw_valid (raw_valid),
		.raw_value (raw_value),
		.cfg       (cfg),
		.vld       (prep_vld),
		.side      (prep_side),
		.span      (prep_span),
		.delta     (prep_dist),
		.half      (prep_half)
	);

	// multiply and divide
	crr_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (prep_vld),
		.side_in (prep_side),
		.span    (prep_span),
		.delta   (prep_dist),
		.half    (prep_half),
		.vld     (div_vld),
		.side    (div_side),
		.quo     (div_quo)
	);

	// final add and output buffering
	crr_outbuf u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.vld_in       (div_vld),
		.side_in      (div_side),
		.quo          (div_quo),
		.dst_center   (cfg.dst_center),
		.scaled_ready (scaled_ready),
		.en           (en),
		.scaled_valid (scaled_valid),
		.scaled_value (scaled_value)
	);

endmodule

FILE: rtl/crr_checker.sv
// ----------------------------------------------------------------------------
// crr_checker
// Port-level checks for the centred range rescale block, bound to the top.
// ----------------------------------------------------------------------------
module crr_checker import crr_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 psel,
	input logic                 penable,
	input logic                 pwrite,
	input logic [ADDR_BITS-1:0] paddr,
	input logic [DATA_BITS-1:0] pwdata,
	input logic [DATA_BITS-1:0] prdata,
	input logic                 pready,
	input logic                 raw_valid,
	input logic                 raw_ready,
	input value_t               raw_value,
	input logic                 scaled_valid,
	input logic                 scaled_ready,
	input value_t               scaled_value
);

	// a held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		scaled_valid && !scaled_ready |=> scaled_valid && $stable(scaled_value))
		else $error("result changed while held");

	// input back-pressure only with a result waiting
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!raw_ready |-> scaled_valid)
		else $error("request refused with no result pending");

	// ready drops only after the output was held off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(raw_ready) |-> $past(scaled_valid && !scaled_ready))
		else $error("ready dropped without output stall");

	// a written register reads back its value
	a_readback: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) && $past(psel && penable && pwrite && pready) && psel && !pwrite
		&& paddr == $past(paddr) && 32'(paddr[ADDR_BITS-1:2]) < REG_COUNT
		|-> prdata[VALUE_BITS-1:0] == $past(pwdata[VALUE_BITS-1:0]))
		else $error("register readback mismatch");

endmodule

bind centered_range_rescale crr_checker u_chk (.*);
